// ===== design/lgbf_pkg.sv =====
package lgbf_pkg;

  localparam int DEF_MAX_NODES = 1024;
  localparam int DEF_MAX_EDGES = 32768;
  localparam int DEF_CAP_BITS  = 17;

  localparam int          CFG_W   = 11;
  localparam logic [30:0] INT_MAX = 31'h7FFF_FFFF;

  localparam logic RK_TOTAL = 1'b0;
  localparam logic RK_EDGE  = 1'b1;

  typedef enum logic [1:0] {
    FN_CLEAR   = 2'd0,
    FN_ADD     = 2'd1,
    FN_COMPUTE = 2'd2,
    FN_READ    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_NODE_COUNT = 2'd0,
    REG_SOURCE     = 2'd1,
    REG_SINK       = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] node_count;
    logic [CFG_W-1:0] source_node;
    logic [CFG_W-1:0] sink_node;
  } cfg_t;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE,
    S_ADD0, S_ADD1, S_ADD2, S_ADD3,
    S_RD0, S_RD1,
    S_FCLR, S_LCLR, S_BINIT,
    S_BQ, S_BU, S_BU2, S_BE, S_BE2, S_BE3, S_BEND,
    S_CA0, S_CA1,
    S_DU, S_DA, S_DS, S_DS2, S_DS3, S_DR0, S_DR1,
    S_AG0, S_AG1, S_AG2, S_AG3,
    S_DONE
  } eng_state_t;

endpackage

// ===== design/level_graph_blocking_flow.sv =====
// Add edge writes both slots of the pair and links them onto the end nodes' chains;
// read edge flow reads the flow slot into the result word; clear resets the chains;
// compute clears 2*edge_count flow slots and node_count levels, builds one level
// graph by a breadth-first search, then walks augmenting paths in it.
// One command at a time: busy stays high until the command ends; add and clear send no word; the receiver cannot stall.
// Reset (rst_n low, synchronous) runs a clearing pass over the chains of nodes 0 to MAX_NODES.
module level_graph_blocking_flow #(
  parameter int MAX_NODES = lgbf_pkg::DEF_MAX_NODES,
  parameter int MAX_EDGES = lgbf_pkg::DEF_MAX_EDGES,
  parameter int CAP_BITS  = lgbf_pkg::DEF_CAP_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [10:0] in_from_node,
  input  logic [10:0] in_to_node,
  input  logic [16:0] in_capacity,
  input  logic [14:0] in_edge_index,
  // result channel: one word per strobe, never held off
  output logic        out_valid,
  output logic        out_result_kind,
  output logic [30:0] out_total_flow,
  output logic [16:0] out_edge_flow,
  output logic [1:0]  out_status,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lgbf_pkg::*;

  // node count, source and sink; hold steady while a command runs
  cfg_t cfg;

  lgbf_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // edge store, adjacency chains, levels, arcs, queue and path stack all
  // live in synchronous memories with registered reads inside the engine; it
  // advances the level search and the augmenting walks one round of memory reads per step
  lgbf_engine #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES),
    .CAP_BITS  (CAP_BITS)
  ) u_engine (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_from_node    (in_from_node),
    .in_to_node      (in_to_node),
    .in_capacity     (in_capacity),
    .in_edge_index   (in_edge_index),
    .cfg             (cfg),
    .out_valid       (out_valid),
    .out_result_kind (out_result_kind),
    .out_total_flow  (out_total_flow),
    .out_edge_flow   (out_edge_flow),
    .out_status      (out_status)
  );

endmodule

// ===== design/lgbf_cfg_regs.sv =====
module lgbf_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output lgbf_pkg::cfg_t      cfg
);
  import lgbf_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (paddr[3:2])
        REG_NODE_COUNT: cfg_nxt.node_count  = pwdata[CFG_W-1:0];
        REG_SOURCE:     cfg_nxt.source_node = pwdata[CFG_W-1:0];
        REG_SINK:       cfg_nxt.sink_node   = pwdata[CFG_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_NODE_COUNT: prdata = 32'(cfg_r.node_count);
      REG_SOURCE:     prdata = 32'(cfg_r.source_node);
      REG_SINK:       prdata = 32'(cfg_r.sink_node);
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.node_count  <= CFG_W'(1);
      cfg_r.source_node <= CFG_W'(1);
      cfg_r.sink_node   <= CFG_W'(1);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== design/lgbf_engine.sv =====
module lgbf_engine #(
  parameter int MAX_NODES = lgbf_pkg::DEF_MAX_NODES,
  parameter int MAX_EDGES = lgbf_pkg::DEF_MAX_EDGES,
  parameter int CAP_BITS  = lgbf_pkg::DEF_CAP_BITS
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  logic [1:0]     in_func,
  input  logic [10:0]    in_from_node,
  input  logic [10:0]    in_to_node,
  input  logic [16:0]    in_capacity,
  input  logic [14:0]    in_edge_index,
  input  lgbf_pkg::cfg_t cfg,
  output logic           out_valid,
  output logic           out_result_kind,
  output logic [30:0]    out_total_flow,
  output logic [16:0]    out_edge_flow,
  output logic [1:0]     out_status
);
  import lgbf_pkg::*;

  localparam int NW    = $clog2(MAX_NODES + 1);
  localparam int SLOTS = 2 * MAX_EDGES;
  localparam int SW    = $clog2(SLOTS);
  localparam int PW    = SW + 1;
  localparam int LW    = NW + 1;
  localparam int QW    = $clog2(MAX_NODES);
  localparam int DW    = $clog2(MAX_NODES + 1);
  localparam int ECW   = $clog2(MAX_EDGES + 1);
  localparam int FW    = CAP_BITS + 1;
  localparam int RW    = CAP_BITS + 2;
  localparam int IXW   = ((SW > NW) ? SW : NW) + 1;
  localparam int SEW   = SW + 31;

  localparam logic [PW-1:0] PTR_NONE = {1'b1, {SW{1'b0}}};
  localparam logic [LW-1:0] LEV_NONE = {LW{1'b1}};

  // memories
  logic [NW-1:0]          tgt_mem [SLOTS];
  logic [CAP_BITS-1:0]    cap_mem [SLOTS];
  logic signed [FW-1:0]   flw_mem [SLOTS];
  logic [PW-1:0]          nxt_mem [SLOTS];
  logic [PW-1:0]          head_mem [MAX_NODES+1];
  logic [PW-1:0]          tail_mem [MAX_NODES+1];
  logic [LW-1:0]          lev_mem [MAX_NODES+1];
  logic [PW-1:0]          arc_mem [MAX_NODES+1];
  logic [NW-1:0]          que_mem [MAX_NODES];
  logic [SEW-1:0]         stk_mem [MAX_NODES];

  logic tgt_we, cap_we, flw_we, nxt_we, head_we, tail_we, lev_we, arc_we, que_we, stk_we;
  logic [SW-1:0] tgt_wa, cap_wa, flw_wa, nxt_wa, tgt_ra, cap_ra, flw_ra, nxt_ra;
  logic [NW-1:0] head_wa, tail_wa, lev_wa, arc_wa, head_ra, tail_ra, lev_ra, arc_ra;
  logic [QW-1:0] que_wa, que_ra, stk_wa, stk_ra;
  logic [NW-1:0]        tgt_wd, que_wd;
  logic [CAP_BITS-1:0]  cap_wd;
  logic signed [FW-1:0] flw_wd;
  logic [PW-1:0]        nxt_wd, head_wd, tail_wd, arc_wd;
  logic [LW-1:0]        lev_wd;
  logic [SEW-1:0]       stk_wd;

  logic [NW-1:0]        tgt_rd_r, que_rd_r;
  logic [CAP_BITS-1:0]  cap_rd_r;
  logic signed [FW-1:0] flw_rd_r;
  logic [PW-1:0]        nxt_rd_r, head_rd_r, tail_rd_r, arc_rd_r;
  logic [LW-1:0]        lev_rd_r;
  logic [SEW-1:0]       stk_rd_r;

  // control and working registers
  eng_state_t st_r, st_nxt;
  logic [IXW-1:0]       ix_r, ix_nxt;
  logic [ECW-1:0]       ecnt_r, ecnt_nxt;
  logic                 full_r, full_nxt;
  logic [NW-1:0]        from_r, from_nxt, to_r, to_nxt;
  logic [CAP_BITS-1:0]  cap_r, cap_nxt;
  logic [14:0]          eidx_r, eidx_nxt;
  logic [NW-1:0]        u_r, u_nxt, v_r, v_nxt;
  logic [LW-1:0]        lev_r, lev_nxt;
  logic [PW-1:0]        arc_r, arc_nxt, nxtp_r, nxtp_nxt;
  logic signed [RW-1:0] res_r, res_nxt;
  logic                 okc_r, okc_nxt;
  logic [DW-1:0]        depth_r, depth_nxt, head_r, head_nxt, tail_r, tail_nxt;
  logic [30:0]          cmin_r, cmin_nxt, total_r, total_nxt;
  logic                 reached_r, reached_nxt;
  logic [SW-1:0]        e_r, e_nxt;
  logic                 ovalid_r, ovalid_nxt, okind_r, okind_nxt;
  logic [30:0]          ototal_r, ototal_nxt;
  logic [16:0]          oedge_r, oedge_nxt;
  logic [1:0]           ostat_r, ostat_nxt;

  // shared decode
  logic [NW-1:0] n_eff, src, snk;
  logic          st_bad, add_ok, accept, tgt_ok, usable, depth_full, ag_last;
  logic [SW-1:0] slot_k, slot_k1, rd_slot, e_twin;
  logic [31:0]   sat_sum;
  logic [30:0]   res31;
  logic signed [FW-1:0] amount;

  assign n_eff = (32'(cfg.node_count) > 32'(MAX_NODES)) ? NW'(MAX_NODES)
                                                         : NW'(cfg.node_count);
  assign src   = NW'(cfg.source_node);
  assign snk   = NW'(cfg.sink_node);
  assign st_bad = (cfg.source_node == '0) || (32'(cfg.source_node) > 32'(n_eff)) ||
                  (cfg.sink_node == '0) || (32'(cfg.sink_node) > 32'(n_eff)) ||
                  (cfg.source_node == cfg.sink_node);
  assign add_ok = (in_from_node != '0) && (32'(in_from_node) <= 32'(MAX_NODES)) &&
                  (in_to_node != '0) && (32'(in_to_node) <= 32'(MAX_NODES));
  assign accept = start && (st_r == S_IDLE);
  assign busy   = (st_r != S_IDLE);

  assign slot_k  = SW'({ecnt_r, 1'b0});
  assign slot_k1 = slot_k | SW'(1);
  assign rd_slot = SW'({eidx_r, 1'b0});
  assign e_twin  = e_r ^ SW'(1);

  assign tgt_ok     = (tgt_rd_r != '0) && (tgt_rd_r <= n_eff);
  assign usable     = (lev_rd_r == lev_r + 1'b1) && !res_r[RW-1] && (res_r != '0);
  assign depth_full = (32'(depth_r) == 32'(MAX_NODES));
  assign ag_last    = (32'(ix_r) + 32'd1 == 32'(depth_r));
  assign res31      = 31'($unsigned(res_r));
  assign amount     = FW'(cmin_r);
  assign sat_sum    = 32'(total_r) + 32'(cmin_r);

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_CLR:  if (32'(ix_r) == 32'(MAX_NODES)) st_nxt = S_IDLE;
      S_IDLE: begin
        if (start) begin
          unique case (func_t'(in_func))
            FN_CLEAR:   st_nxt = S_CLR;
            FN_ADD:     if (add_ok && 32'(ecnt_r) < 32'(MAX_EDGES)) st_nxt = S_ADD0;
            FN_COMPUTE: st_nxt = S_FCLR;
            FN_READ:    st_nxt = S_RD0;
            default:    st_nxt = S_IDLE;
          endcase
        end
      end
      S_ADD0: st_nxt = S_ADD1;
      S_ADD1: st_nxt = S_ADD2;
      S_ADD2: st_nxt = S_ADD3;
      S_ADD3: st_nxt = S_IDLE;
      S_RD0:  st_nxt = S_RD1;
      S_RD1:  st_nxt = S_IDLE;
      S_FCLR: if (32'(ix_r) >= 32'({ecnt_r, 1'b0})) st_nxt = S_LCLR;
      S_LCLR: if (32'(ix_r) > 32'(n_eff)) st_nxt = st_bad ? S_DONE : S_BINIT;
      S_BINIT: st_nxt = S_BQ;
      S_BQ:   st_nxt = (head_r == tail_r) ? S_BEND : S_BU;
      S_BU:   st_nxt = S_BU2;
      S_BU2:  st_nxt = S_BE;
      S_BE:   st_nxt = arc_r[SW] ? S_BQ : S_BE2;
      S_BE2:  st_nxt = tgt_ok ? S_BE3 : S_BE;
      S_BE3:  st_nxt = S_BE;
      S_BEND: st_nxt = reached_r ? S_CA0 : S_DONE;
      S_CA0:  st_nxt = (32'(ix_r) <= 32'(n_eff)) ? S_CA1 : S_DU;
      S_CA1:  st_nxt = S_CA0;
      S_DU:   st_nxt = (u_r == snk) ? S_AG0 : S_DA;
      S_DA:   st_nxt = S_DS;
      S_DS: begin
        if (!arc_r[SW])          st_nxt = S_DS2;
        else if (depth_r == '0)  st_nxt = S_DONE;
        else                     st_nxt = S_DR0;
      end
      S_DS2:  st_nxt = tgt_ok ? S_DS3 : S_DS;
      S_DS3: begin
        if (!usable)          st_nxt = S_DS;
        else if (depth_full)  st_nxt = S_DR0;
        else                  st_nxt = S_DU;
      end
      S_DR0:  st_nxt = S_DR1;
      S_DR1:  st_nxt = S_DS;
      S_AG0:  st_nxt = S_AG1;
      S_AG1:  st_nxt = S_AG2;
      S_AG2:  st_nxt = S_AG3;
      S_AG3:  st_nxt = ag_last ? S_DU : S_AG0;
      S_DONE: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    ix_nxt = ix_r;   ecnt_nxt = ecnt_r;   full_nxt = full_r;
    from_nxt = from_r; to_nxt = to_r; cap_nxt = cap_r; eidx_nxt = eidx_r;
    u_nxt = u_r; v_nxt = v_r; lev_nxt = lev_r; arc_nxt = arc_r; nxtp_nxt = nxtp_r;
    res_nxt = res_r; okc_nxt = okc_r; depth_nxt = depth_r;
    head_nxt = head_r; tail_nxt = tail_r; cmin_nxt = cmin_r; total_nxt = total_r;
    reached_nxt = reached_r; e_nxt = e_r;
    ovalid_nxt = 1'b0; okind_nxt = okind_r; ototal_nxt = ototal_r;
    oedge_nxt = oedge_r; ostat_nxt = ostat_r;

    tgt_we = 1'b0; cap_we = 1'b0; flw_we = 1'b0; nxt_we = 1'b0;
    head_we = 1'b0; tail_we = 1'b0; lev_we = 1'b0; arc_we = 1'b0;
    que_we = 1'b0; stk_we = 1'b0;
    tgt_wa = '0; cap_wa = '0; flw_wa = '0; nxt_wa = '0;
    tgt_ra = '0; cap_ra = '0; flw_ra = '0; nxt_ra = '0;
    head_wa = '0; tail_wa = '0; lev_wa = '0; arc_wa = '0;
    head_ra = '0; tail_ra = '0; lev_ra = '0; arc_ra = '0;
    que_wa = '0; que_ra = '0; stk_wa = '0; stk_ra = '0;
    tgt_wd = '0; que_wd = '0; cap_wd = '0; flw_wd = '0;
    nxt_wd = PTR_NONE; head_wd = PTR_NONE; tail_wd = PTR_NONE; arc_wd = PTR_NONE;
    lev_wd = LEV_NONE; stk_wd = '0;

    case (st_r)
      S_CLR: begin
        head_we = 1'b1; tail_we = 1'b1;
        head_wa = ix_r[NW-1:0]; tail_wa = ix_r[NW-1:0];
        ix_nxt  = ix_r + 1'b1;
      end
      S_IDLE: begin
        if (accept) begin
          case (func_t'(in_func))
            FN_CLEAR: begin
              ix_nxt = '0; ecnt_nxt = '0; full_nxt = 1'b0;
            end
            FN_ADD: begin
              if (add_ok && 32'(ecnt_r) >= 32'(MAX_EDGES)) full_nxt = 1'b1;
              from_nxt = NW'(in_from_node);
              to_nxt   = NW'(in_to_node);
              cap_nxt  = CAP_BITS'(in_capacity);
            end
            FN_COMPUTE: begin
              ix_nxt = '0; total_nxt = '0;
            end
            default: eidx_nxt = in_edge_index;
          endcase
        end
      end
      S_ADD0: begin
        tgt_we = 1'b1; cap_we = 1'b1; flw_we = 1'b1; nxt_we = 1'b1;
        tgt_wa = slot_k; cap_wa = slot_k; flw_wa = slot_k; nxt_wa = slot_k;
        tgt_wd = to_r; cap_wd = cap_r;
        tail_ra = from_r;
      end
      S_ADD1: begin
        tgt_we = 1'b1; cap_we = 1'b1; flw_we = 1'b1; nxt_we = 1'b1;
        tgt_wa = slot_k1; cap_wa = slot_k1; flw_wa = slot_k1; nxt_wa = slot_k1;
        tgt_wd = from_r;
        nxtp_nxt = tail_rd_r;
        tail_we = 1'b1; tail_wa = from_r; tail_wd = {1'b0, slot_k};
        if (tail_rd_r[SW]) begin
          head_we = 1'b1; head_wa = from_r; head_wd = {1'b0, slot_k};
        end
      end
      S_ADD2: begin
        if (!nxtp_r[SW]) begin
          nxt_we = 1'b1; nxt_wa = nxtp_r[SW-1:0]; nxt_wd = {1'b0, slot_k};
        end
        tail_ra = to_r;
      end
      S_ADD3: begin
        tail_we = 1'b1; tail_wa = to_r; tail_wd = {1'b0, slot_k1};
        if (tail_rd_r[SW]) begin
          head_we = 1'b1; head_wa = to_r; head_wd = {1'b0, slot_k1};
        end else begin
          nxt_we = 1'b1; nxt_wa = tail_rd_r[SW-1:0]; nxt_wd = {1'b0, slot_k1};
        end
        ecnt_nxt = ecnt_r + 1'b1;
      end
      S_RD0: flw_ra = rd_slot;
      S_RD1: begin
        ovalid_nxt = 1'b1; okind_nxt = RK_EDGE; ototal_nxt = '0;
        if (32'(eidx_r) < 32'(ecnt_r)) begin
          oedge_nxt = (!flw_rd_r[FW-1] && flw_rd_r != '0) ? 17'($unsigned(flw_rd_r)) : '0;
          ostat_nxt = STS_OK;
        end else begin
          oedge_nxt = '0;
          ostat_nxt = STS_RANGE;
        end
      end
      S_FCLR: begin
        if (32'(ix_r) < 32'({ecnt_r, 1'b0})) begin
          flw_we = 1'b1; flw_wa = ix_r[SW-1:0];
          ix_nxt = ix_r + 1'b1;
        end else begin
          ix_nxt = IXW'(1);
        end
      end
      S_LCLR: begin
        if (32'(ix_r) <= 32'(n_eff)) begin
          lev_we = 1'b1; lev_wa = ix_r[NW-1:0];
          ix_nxt = ix_r + 1'b1;
        end
      end
      S_BINIT: begin
        lev_we = 1'b1; lev_wa = src; lev_wd = '0;
        que_we = 1'b1; que_wa = '0; que_wd = src;
        head_nxt = '0; tail_nxt = DW'(1); reached_nxt = 1'b0;
      end
      S_BQ: begin
        que_ra = head_r[QW-1:0];
        if (head_r != tail_r) head_nxt = head_r + 1'b1;
      end
      S_BU: begin
        u_nxt = que_rd_r; head_ra = que_rd_r; lev_ra = que_rd_r;
      end
      S_BU2: begin
        lev_nxt = lev_rd_r; arc_nxt = head_rd_r;
      end
      S_BE: begin
        tgt_ra = arc_r[SW-1:0]; cap_ra = arc_r[SW-1:0]; nxt_ra = arc_r[SW-1:0];
      end
      S_BE2: begin
        v_nxt = tgt_rd_r; nxtp_nxt = nxt_rd_r; okc_nxt = (cap_rd_r != '0);
        lev_ra = tgt_rd_r;
        if (!tgt_ok) arc_nxt = nxt_rd_r;
      end
      S_BE3: begin
        if (lev_rd_r == LEV_NONE && okc_r) begin
          lev_we = 1'b1; lev_wa = v_r; lev_wd = lev_r + 1'b1;
          if (32'(tail_r) < 32'(MAX_NODES)) begin
            que_we = 1'b1; que_wa = tail_r[QW-1:0]; que_wd = v_r;
            tail_nxt = tail_r + 1'b1;
          end
          if (v_r == snk) reached_nxt = 1'b1;
        end
        arc_nxt = nxtp_r;
      end
      S_BEND: ix_nxt = IXW'(1);
      S_CA0: begin
        head_ra = ix_r[NW-1:0];
        if (32'(ix_r) > 32'(n_eff)) begin
          u_nxt = src; depth_nxt = '0; cmin_nxt = INT_MAX; lev_nxt = '0;
        end
      end
      S_CA1: begin
        arc_we = 1'b1; arc_wa = ix_r[NW-1:0]; arc_wd = head_rd_r;
        ix_nxt = ix_r + 1'b1;
      end
      S_DU: begin
        arc_ra = u_r;
        ix_nxt = '0;
      end
      S_DA: arc_nxt = arc_rd_r;
      S_DS: begin
        tgt_ra = arc_r[SW-1:0]; cap_ra = arc_r[SW-1:0];
        flw_ra = arc_r[SW-1:0]; nxt_ra = arc_r[SW-1:0];
        stk_ra = QW'(depth_r - 1'b1);
        if (arc_r[SW]) begin
          arc_we = 1'b1; arc_wa = u_r; arc_wd = PTR_NONE;
        end
      end
      S_DS2: begin
        v_nxt = tgt_rd_r; nxtp_nxt = nxt_rd_r;
        res_nxt = $signed({2'b00, cap_rd_r}) - $signed({flw_rd_r[FW-1], flw_rd_r});
        lev_ra = tgt_rd_r;
        if (!tgt_ok) arc_nxt = nxt_rd_r;
      end
      S_DS3: begin
        stk_ra = QW'(depth_r - 1'b1);
        if (usable) begin
          arc_we = 1'b1; arc_wa = u_r; arc_wd = arc_r;
          if (!depth_full) begin
            stk_we = 1'b1; stk_wa = depth_r[QW-1:0]; stk_wd = {arc_r[SW-1:0], cmin_r};
            if (res31 < cmin_r) cmin_nxt = res31;
            depth_nxt = depth_r + 1'b1;
            u_nxt = v_r;
            lev_nxt = lev_r + 1'b1;
          end
        end else begin
          arc_nxt = nxtp_r;
        end
      end
      S_DR0: begin
        e_nxt = stk_rd_r[SEW-1 -: SW];
        cmin_nxt = stk_rd_r[30:0];
        tgt_ra = stk_rd_r[SEW-1 -: SW] ^ SW'(1);
        nxt_ra = stk_rd_r[SEW-1 -: SW];
      end
      S_DR1: begin
        u_nxt = tgt_rd_r; arc_nxt = nxt_rd_r;
        arc_we = 1'b1; arc_wa = tgt_rd_r; arc_wd = nxt_rd_r;
        depth_nxt = depth_r - 1'b1;
        lev_nxt = lev_r - 1'b1;
      end
      S_AG0: stk_ra = ix_r[QW-1:0];
      S_AG1: begin
        e_nxt = stk_rd_r[SEW-1 -: SW];
        flw_ra = stk_rd_r[SEW-1 -: SW];
      end
      S_AG2: begin
        flw_we = 1'b1; flw_wa = e_r; flw_wd = flw_rd_r + amount;
        flw_ra = e_twin;
      end
      S_AG3: begin
        flw_we = 1'b1; flw_wa = e_twin; flw_wd = flw_rd_r - amount;
        ix_nxt = ix_r + 1'b1;
        if (ag_last) begin
          total_nxt = (sat_sum > 32'(INT_MAX)) ? INT_MAX : sat_sum[30:0];
          u_nxt = src; depth_nxt = '0; cmin_nxt = INT_MAX; lev_nxt = '0;
        end
      end
      S_DONE: begin
        ovalid_nxt = 1'b1; okind_nxt = RK_TOTAL; ototal_nxt = total_r;
        oedge_nxt = '0; ostat_nxt = full_r ? STS_FULL : STS_OK;
      end
      default: ;
    endcase
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (tgt_we) tgt_mem[tgt_wa] <= tgt_wd;
    tgt_rd_r <= tgt_mem[tgt_ra];
  end
  always_ff @(posedge clk) begin
    if (cap_we) cap_mem[cap_wa] <= cap_wd;
    cap_rd_r <= cap_mem[cap_ra];
  end
  always_ff @(posedge clk) begin
    if (flw_we) flw_mem[flw_wa] <= flw_wd;
    flw_rd_r <= flw_mem[flw_ra];
  end
  always_ff @(posedge clk) begin
    if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
    nxt_rd_r <= nxt_mem[nxt_ra];
  end
  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    head_rd_r <= head_mem[head_ra];
  end
  always_ff @(posedge clk) begin
    if (tail_we) tail_mem[tail_wa] <= tail_wd;
    tail_rd_r <= tail_mem[tail_ra];
  end
  always_ff @(posedge clk) begin
    if (lev_we) lev_mem[lev_wa] <= lev_wd;
    lev_rd_r <= lev_mem[lev_ra];
  end
  always_ff @(posedge clk) begin
    if (arc_we) arc_mem[arc_wa] <= arc_wd;
    arc_rd_r <= arc_mem[arc_ra];
  end
  always_ff @(posedge clk) begin
    if (que_we) que_mem[que_wa] <= que_wd;
    que_rd_r <= que_mem[que_ra];
  end
  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    stk_rd_r <= stk_mem[stk_ra];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_CLR;
      ix_r     <= '0;
      ecnt_r   <= '0;
      full_r   <= 1'b0;
      depth_r  <= '0;
      head_r   <= '0;
      tail_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      ix_r     <= ix_nxt;
      ecnt_r   <= ecnt_nxt;
      full_r   <= full_nxt;
      depth_r  <= depth_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    from_r <= from_nxt; to_r <= to_nxt; cap_r <= cap_nxt; eidx_r <= eidx_nxt;
    u_r <= u_nxt; v_r <= v_nxt; lev_r <= lev_nxt; arc_r <= arc_nxt; nxtp_r <= nxtp_nxt;
    res_r <= res_nxt; okc_r <= okc_nxt; cmin_r <= cmin_nxt; total_r <= total_nxt;
    reached_r <= reached_nxt; e_r <= e_nxt;
    okind_r <= okind_nxt; ototal_r <= ototal_nxt; oedge_r <= oedge_nxt; ostat_r <= ostat_nxt;
  end

  assign out_valid       = ovalid_r;
  assign out_result_kind = okind_r;
  assign out_total_flow  = ototal_r;
  assign out_edge_flow   = oedge_r;
  assign out_status      = ostat_r;

  a_word_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(st_r) == S_DONE || $past(st_r) == S_RD1))
    else $error("result word without a finishing state");

  a_push_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DS3 && usable && !depth_full) |=> (depth_r == $past(depth_r) + 1'b1))
    else $error("path stack push lost");

  a_edge_count: assert property (@(posedge clk) disable iff (!rst_n)
    32'(ecnt_r) <= 32'(MAX_EDGES))
    else $error("edge count beyond store");

  a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_BQ || st_r == S_BE || st_r == S_BE3) |-> (head_r <= tail_r))
    else $error("level queue head passed tail");

  a_total_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind == RK_TOTAL) |-> (out_status != STS_RANGE))
    else $error("range status on a total word");

endmodule
